[src/mcr_pkg.sv]
// Shared constants for the midpoint circle rasterizer.
// No dependencies; imported by the front, back and top-level modules.
package mcr_pkg;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam int GROUP_PIXELS = 8;
    localparam int IDX_BITS     = $clog2(GROUP_PIXELS);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(GROUP_PIXELS - 1);

endpackage

[src/mcr_front.sv]
// Front end: accepts start/step transfers, holds the octant state and the decision term,
// and emits one packed group descriptor {done, cx, cy, x, y} per plotted group.
// Depends on mcr_pkg.
module mcr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic                      mode,
    input  logic [COORD_BITS-1:0]     center_x,
    input  logic [COORD_BITS-1:0]     center_y,
    input  logic [COORD_BITS-1:0]     radius,
    output logic                      push,
    output logic [4*COORD_BITS:0]     group
);
    import mcr_pkg::*;

    localparam int DEC_BITS = COORD_BITS + 4;
    localparam int EXT_BITS = DEC_BITS - COORD_BITS;

    logic [COORD_BITS-1:0]      x_reg, x_next;
    logic [COORD_BITS-1:0]      y_reg, y_next;
    logic [COORD_BITS-1:0]      cx_reg, cx_next;
    logic [COORD_BITS-1:0]      cy_reg, cy_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic                       active_reg, active_next;
    logic                       done;

    logic [COORD_BITS-1:0]      x_inc, y_dec;
    logic signed [DEC_BITS-1:0] x_inc_s, y_dec_s, diff_s;

    always_comb begin
        x_inc   = x_reg + COORD_BITS'(1);
        y_dec   = y_reg - COORD_BITS'(1);
        x_inc_s = signed'({{EXT_BITS{1'b0}}, x_inc});
        y_dec_s = signed'({{EXT_BITS{1'b0}}, y_dec});
        diff_s  = x_inc_s - y_dec_s;
    end

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        done        = 1'b0;
        push        = 1'b0;
        if (accept) begin
            if (mode == MODE_START) begin
                cx_next     = center_x;
                cy_next     = center_y;
                x_next      = '0;
                y_next      = radius;
                dec_next    = DEC_BITS'(1) - signed'({{EXT_BITS{1'b0}}, radius});
                done        = (radius == '0);
                active_next = !done;
                push        = 1'b1;
            end else if (active_reg) begin
                x_next = x_inc;
                if (dec_reg[DEC_BITS-1]) begin
                    dec_next = dec_reg + (x_inc_s <<< 1) + DEC_BITS'(3);
                end else begin
                    y_next   = y_dec;
                    dec_next = dec_reg + (diff_s <<< 1) + DEC_BITS'(5);
                end
                done        = (x_next >= y_next);
                active_next = !done;
                push        = 1'b1;
            end
        end
    end

    assign group = {done, cx_next, cy_next, x_next, y_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end else begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
        end
    end

endmodule

[src/mcr_queue.sv]
// Two-entry group queue between the front and back ends.
// No package dependencies.
module mcr_queue #(
    parameter int WIDTH = 49
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[src/mcr_back.sv]
// Back end: walks the eight mirrored pixels of the head group into a registered output stage.
// Depends on mcr_pkg.
module mcr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  logic [4*COORD_BITS:0]       head_data,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COORD_BITS+1:0] m_pixel_x,
    output logic signed [COORD_BITS+1:0] m_pixel_y,
    output logic                        m_last_of_run,
    output logic                        m_circle_done
);
    import mcr_pkg::*;

    localparam int PIX_BITS = COORD_BITS + 2;

    logic                       done;
    logic [COORD_BITS-1:0]      cx, cy, ox, oy;
    logic [IDX_BITS-1:0]        idx_reg;
    logic                       load;
    logic signed [PIX_BITS-1:0] base_x, base_y, off_x, off_y, px, py;

    logic                       valid_reg;
    logic signed [PIX_BITS-1:0] px_reg, py_reg;
    logic                       last_reg, done_reg;

    assign {done, cx, cy, ox, oy} = head_data;

    assign load = head_valid && (!valid_reg || m_ready);
    assign pop  = load && (idx_reg == IDX_LAST);

    always_comb begin
        base_x = signed'(PIX_BITS'(cx));
        base_y = signed'(PIX_BITS'(cy));
        off_x  = signed'(PIX_BITS'(idx_reg[2] ? oy : ox));
        off_y  = signed'(PIX_BITS'(idx_reg[2] ? ox : oy));
        px     = idx_reg[0] ? base_x - off_x : base_x + off_x;
        py     = idx_reg[1] ? base_y - off_y : base_y + off_y;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= (idx_reg == IDX_LAST);
            done_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_reg + IDX_BITS'(1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_last_of_run = last_reg;
    assign m_circle_done = done_reg;

endmodule

[src/midpoint_circle_rasterizer.sv]
// Midpoint circle rasterizer: front end updates the octant, back end serializes pixels.
// An item transfer writes its group into the queue; the back end then registers each
// pixel in its output stage, one pixel per cycle while m_ready is high and a group is
// queued; a two-entry group queue lets the front run ahead.
// Reset (aresetn, synchronous, active low) clears the octant state, queue and output.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [COORD_BITS-1:0]        s_center_x,
    input  logic [COORD_BITS-1:0]        s_center_y,
    input  logic [COORD_BITS-1:0]        s_radius,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS+1:0] m_pixel_x,
    output logic signed [COORD_BITS+1:0] m_pixel_y,
    output logic                         m_last_of_run,
    output logic                         m_circle_done
);
    import mcr_pkg::*;

    localparam int GROUP_BITS = 4 * COORD_BITS + 1;

    logic                  accept;
    logic                  push, full, pop, head_valid;
    logic [GROUP_BITS-1:0] group, head_data;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .mode     (s_mode),
        .center_x (s_center_x),
        .center_y (s_center_y),
        .radius   (s_radius),
        .push     (push),
        .group    (group)
    );

    mcr_queue #(.WIDTH(GROUP_BITS)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (group),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_last_of_run (m_last_of_run),
        .m_circle_done (m_circle_done)
    );

endmodule

[sim/midpoint_circle_rasterizer_tb.sv]
// Self-checking testbench for midpoint_circle_rasterizer: drives start and step transfers,
// predicts every mirrored pixel group and checks the pixel stream in order.
// Depends on mcr_pkg and the rasterizer RTL.
module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    localparam int CW             = 12;
    localparam int PW             = CW + 2;
    localparam int RANDOM_ITEMS   = 220;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_PRINTED    = 40;
    localparam int IDLE_PCT[4]    = '{0, 60, 0, 18};
    localparam int STALL_PCT[4]   = '{0, 0, 60, 18};

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 last;
        logic                 done;
    } pixel_t;

    class pixel_board;
        bit [CW-1:0] center_x;
        bit [CW-1:0] center_y;
        bit [CW-1:0] off_x;
        bit [CW-1:0] off_y;
        int          decision;
        bit          active;
        pixel_t      expected_pixels[$];
        int          errors;

        function void plot_group(bit done);
            int cx, cy, x, y;
            int px[GROUP_PIXELS];
            int py[GROUP_PIXELS];
            pixel_t p;
            cx = center_x;
            cy = center_y;
            x  = off_x;
            y  = off_y;
            px = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
            py = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
            for (int k = 0; k < GROUP_PIXELS; k++) begin
                p.x    = PW'(px[k]);
                p.y    = PW'(py[k]);
                p.last = (k == GROUP_PIXELS - 1);
                p.done = done;
                expected_pixels.push_back(p);
            end
        endfunction

        function void note_transfer(logic mode, bit [CW-1:0] cx, bit [CW-1:0] cy,
                                    bit [CW-1:0] r);
            if (mode == MODE_START) begin
                center_x = cx;
                center_y = cy;
                off_x    = '0;
                off_y    = r;
                decision = 1 - int'(r);
                active   = (off_x < off_y);
                plot_group(!active);
            end else if (active) begin
                off_x++;
                if (decision < 0) begin
                    decision += 2 * int'(off_x) + 3;
                end else begin
                    off_y--;
                    decision += 2 * (int'(off_x) - int'(off_y)) + 5;
                end
                active = (off_x < off_y);
                plot_group(!active);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR: %s", what);
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) with nothing pending", got.x, got.y));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
                got.done !== want.done)
                report($sformatf("pixel (%0d,%0d) last %b done %b, want (%0d,%0d) last %b done %b",
                                 got.x, got.y, got.last, got.done,
                                 want.x, want.y, want.last, want.done));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [CW-1:0]        s_center_x;
    logic [CW-1:0]        s_center_y;
    logic [CW-1:0]        s_radius;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [PW-1:0] m_pixel_x;
    logic signed [PW-1:0] m_pixel_y;
    logic                 m_last_of_run;
    logic                 m_circle_done;

    pixel_board board = new;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         counted_items;
    int         quiet_cycles;

    midpoint_circle_rasterizer #(
        .COORD_BITS(CW)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_last_of_run (m_last_of_run),
        .m_circle_done (m_circle_done)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_pixel({m_pixel_x, m_pixel_y, m_last_of_run, m_circle_done});
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("midpoint_circle_rasterizer_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic mode, logic [CW-1:0] cx, logic [CW-1:0] cy,
                             logic [CW-1:0] r);
        if (mode == MODE_START || board.active)
            counted_items++;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius   <= r;
        do @(posedge aclk); while (!s_ready);
        board.note_transfer(mode, cx, cy, r);
    endtask

    task automatic draw_circle(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] r,
                               int max_steps);
        send_item(MODE_START, cx, cy, r);
        for (int i = 0; i < max_steps && board.active; i++)
            send_item(MODE_STEP, CW'($urandom), CW'($urandom), CW'($urandom));
    endtask

    initial begin
        int directed_items;
        int phase;
        int roll;
        counted_items      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_mode     <= MODE_START;
        s_center_x <= '0;
        s_center_y <= '0;
        s_radius   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        draw_circle('0, '0, '0, 0);
        send_item(MODE_STEP, '1, '1, '1);
        draw_circle('1, '1, '1, 3);
        draw_circle('0, '0, '1, 2);
        draw_circle(12'd2048, 12'd1000, 12'd1, 4);
        send_item(MODE_STEP, '0, '0, '0);
        draw_circle(12'd100, 12'd3000, 12'd5, 8);
        draw_circle(12'd0, 12'd4095, 12'd3, 8);

        directed_items = counted_items;
        while (counted_items - directed_items < RANDOM_ITEMS) begin
            phase              = (counted_items - directed_items) * 4 / RANDOM_ITEMS;
            sender_idle_pct    = IDLE_PCT[phase];
            receiver_stall_pct = STALL_PCT[phase];
            roll               = $urandom_range(0, 99);
            if (roll < 10)
                draw_circle(CW'($urandom), CW'($urandom), CW'($urandom),
                            $urandom_range(0, 5));
            else if (roll < 20)
                send_item(MODE_STEP, CW'($urandom), CW'($urandom), CW'($urandom));
            else
                draw_circle(CW'($urandom), CW'($urandom), CW'($urandom_range(0, 24)),
                            (roll < 85) ? 64 : $urandom_range(0, 4));
        end
        s_valid <= 1'b0;

        while (board.expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("midpoint_circle_rasterizer_tb: done, clean");
        else
            $display("midpoint_circle_rasterizer_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_queue.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer.sv
sim/midpoint_circle_rasterizer_tb.sv
